[rtl/ccp_pkg.sv]
// Shared constants and types of the character class partitioner.
`timescale 1ns / 1ps
package ccp_pkg;

	localparam int CHARS   = 256;
	localparam int CHAR_W  = 8;
	localparam int GROUP_W = 9;
	localparam int SLOT_W  = 5;
	localparam int MODE_W  = 3;
	localparam int CGRP_W  = 12;
	localparam int CCNT_W  = 6;
	localparam int TOFF_W  = 10;
	localparam int CIDX_W  = 8;
	localparam int CDAT_W  = 16;

	// command codes
	localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD       = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INVERT    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SUBTRACT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PARTITION = 3'd4;
	localparam logic [MODE_W-1:0] MODE_LOOKUP    = 3'd5;
	localparam logic [MODE_W-1:0] MODE_MEMBER    = 3'd6;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_CLASS_COUNT  = 8'd0;
	localparam logic [CIDX_W-1:0] REG_TOKEN_OFFSET = 8'd1;

	localparam logic [GROUP_W-1:0] MAX_GROUPS = 9'd256;
	localparam logic [CGRP_W-1:0]  NO_GROUP   = 12'hFFF;

	// write side of the group tables
	typedef struct packed {
		logic              ctg_clear;
		logic              ctg_we;
		logic [CHAR_W-1:0] ctg_addr;
		logic [CHAR_W-1:0] ctg_group;
		logic              gm_we;
		logic [CHAR_W-1:0] gm_addr;
	} tbl_wr_t;

endpackage

[rtl/ccp_if.sv]
// Handshake channels of the character class partitioner.
`timescale 1ns / 1ps
interface ccp_in_if;
	logic                         valid;
	logic                         ready;
	logic [ccp_pkg::MODE_W-1:0]   mode;
	logic [ccp_pkg::SLOT_W-1:0]   class_slot;
	logic [ccp_pkg::SLOT_W-1:0]   other_slot;
	logic [ccp_pkg::CHAR_W-1:0]   start_char;
	logic [ccp_pkg::CHAR_W-1:0]   last_char;
	logic [ccp_pkg::CHAR_W-1:0]   group_index;
	modport source (output valid, mode, class_slot, other_slot, start_char, last_char,
		group_index, input ready);
	modport sink (input valid, mode, class_slot, other_slot, start_char, last_char,
		group_index, output ready);
endinterface

interface ccp_out_if;
	logic                              valid;
	logic                              ready;
	logic [ccp_pkg::GROUP_W-1:0]       group_count;
	logic signed [ccp_pkg::CGRP_W-1:0] char_group;
	logic                              is_member;
	modport source (output valid, group_count, char_group, is_member, input ready);
	modport sink (input valid, group_count, char_group, is_member, output ready);
endinterface

interface ccp_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ccp_pkg::CIDX_W-1:0] index;
	logic [ccp_pkg::CDAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/char_class_partitioner_top.sv]
// Top level of the character class partitioner: command sequencer and result register.
`timescale 1ns / 1ps
// Usage notes
//  - in_ch carries one command word (mode, slots, chars, group); out_ch returns exactly
//    one result word per command; cfg writes class_count (index 0), token_offset (1),
//    always ready; the user writes it only while no command is in flight, unenforced.
//  - One command at a time: in_ch.ready is high only when the sequencer is idle.
//  - Edits: clear writes directly; add/invert read the row, then write it; subtract
//    reads both rows, then writes; lookups use a registered read of the table memory.
//  - Partition: n = active classes. A union pass reads classes 0..n-1, then per group
//    a class pass reads them again and a mark sweep walks from the group's low character
//    to 255 over the new group's characters; the low-character pointer walks 0..255
//    once in total. The run time is set by the single read port of the class memory
//    and the single write port of the character table.
//  - Reset: every class empty, no groups, all characters in no group; row and
//    character valid flags clear at once, so no sweep after reset.
//  - A stalled receiver holds the result register; the sequencer waits in its
//    response state until the earlier result has left, and then loads its own.
module char_class_partitioner_top #(
	parameter int MAX_CLASSES = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	ccp_in_if.sink   in_ch,
	ccp_out_if.source out_ch,
	ccp_cfg_if.sink  cfg
);

	localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int NW = $clog2(MAX_CLASSES + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_EXEC  = 9'b000000010,
		S_APPLY = 9'b000000100,
		S_SUB   = 9'b000001000,
		S_UNION = 9'b000010000,
		S_FIND  = 9'b000100000,
		S_KEEP  = 9'b001000000,
		S_MARK  = 9'b010000000,
		S_RESP  = 9'b100000000
	} state_t;

	state_t state_q;

	// latched command word
	logic [ccp_pkg::MODE_W-1:0] mode_q;
	logic [ccp_pkg::SLOT_W-1:0] slot_q, other_q;
	logic [ccp_pkg::CHAR_W-1:0] first_q, last_q, gidx_q;

	// configuration
	logic [ccp_pkg::CCNT_W-1:0] class_count_q;
	logic [ccp_pkg::TOFF_W-1:0] token_offset_q;

	// partition working state
	logic [ccp_pkg::CHARS-1:0]   rem_q, keep_q, drop_q;
	logic [MAX_CLASSES-1:0]      sig_q;
	logic [ccp_pkg::GROUP_W-1:0] groups_q;
	logic [ccp_pkg::CHAR_W-1:0]  ptr_q, scan_q;
	logic [NW-1:0]               n_q, iss_q;
	logic                        rv_s1;
	logic [AW-1:0]               ridx_s1;

	// result
	logic                        out_valid_q;
	logic [ccp_pkg::GROUP_W-1:0] out_gc_q;
	logic signed [ccp_pkg::CGRP_W-1:0] res_cg_q, out_cg_q;
	logic                        res_mb_q, out_mb_q;

	// memory ports
	logic                      cm_re, cm_we;
	logic [AW-1:0]             cm_raddr, cm_waddr;
	logic [ccp_pkg::CHARS-1:0] cm_rdata, cm_wdata;
	ccp_pkg::tbl_wr_t          tw;
	logic                      tb_re;
	logic                      ctg_hit;
	logic [ccp_pkg::CHAR_W-1:0] ctg_group;
	logic [MAX_CLASSES-1:0]    gm_rdata;

	logic                      slot_ok, other_ok, issuing, stream_done;
	logic [ccp_pkg::CHAR_W-1:0] lo_c, hi_c;
	logic [ccp_pkg::CHARS-1:0] range_mask;
	logic [NW-1:0]             active_n;
	logic [AW-1:0]             slot_idx;

	assign slot_ok  = 32'(slot_q) < MAX_CLASSES;
	assign other_ok = 32'(other_q) < MAX_CLASSES;
	assign slot_idx = AW'(slot_q);

	// class_count saturates at the number of slots
	assign active_n = (32'(class_count_q) > MAX_CLASSES) ? NW'(MAX_CLASSES)
		: NW'(class_count_q);

	// streaming read of classes 0..n-1
	assign issuing     = (iss_q < n_q);
	assign stream_done = !issuing && !rv_s1;

	// add-range mask, ends swapped when reversed
	assign lo_c = (first_q > last_q) ? last_q : first_q;
	assign hi_c = (first_q > last_q) ? first_q : last_q;
	always_comb begin
		for (int i = 0; i < ccp_pkg::CHARS; i++)
			range_mask[i] = (8'(i) >= lo_c) && (8'(i) <= hi_c);
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;

	always_comb begin
		cm_re    = 1'b0;
		cm_raddr = slot_idx;
		cm_we    = 1'b0;
		cm_waddr = slot_idx;
		cm_wdata = '0;
		tb_re    = 1'b0;
		tw       = '0;
		tw.ctg_addr  = scan_q;
		tw.ctg_group = groups_q[ccp_pkg::CHAR_W-1:0];
		tw.gm_addr   = groups_q[ccp_pkg::CHAR_W-1:0];
		unique case (state_q)
			S_EXEC: begin
				unique case (mode_q)
					ccp_pkg::MODE_CLEAR: cm_we = slot_ok;
					ccp_pkg::MODE_ADD, ccp_pkg::MODE_INVERT: cm_re = 1'b1;
					ccp_pkg::MODE_SUBTRACT: begin
						cm_re    = 1'b1;
						cm_raddr = AW'(other_q);
					end
					ccp_pkg::MODE_PARTITION: tw.ctg_clear = 1'b1;
					ccp_pkg::MODE_LOOKUP, ccp_pkg::MODE_MEMBER: tb_re = 1'b1;
					default: ;
				endcase
			end
			S_APPLY: begin
				unique case (mode_q)
					ccp_pkg::MODE_ADD: begin
						cm_we    = slot_ok;
						cm_wdata = cm_rdata | range_mask;
					end
					ccp_pkg::MODE_INVERT: begin
						cm_we    = slot_ok;
						cm_wdata = ~cm_rdata;
					end
					ccp_pkg::MODE_SUBTRACT: cm_re = 1'b1;
					default: ;
				endcase
			end
			S_SUB: begin
				cm_we    = slot_ok && other_ok;
				cm_wdata = cm_rdata & ~keep_q;
			end
			S_UNION, S_KEEP: begin
				cm_re    = issuing;
				cm_raddr = iss_q[AW-1:0];
				if (state_q == S_KEEP && stream_done)
					tw.gm_we = 1'b1;
			end
			S_MARK: tw.ctg_we = keep_q[scan_q];
			default: ;
		endcase
	end

	ccp_class_mem #(.ROWS(MAX_CLASSES), .AW(AW)) u_cls (
		.clk(clk), .arst_n(arst_n),
		.re(cm_re), .raddr(cm_raddr), .rdata(cm_rdata),
		.we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata)
	);

	ccp_tables #(.CLASSES(MAX_CLASSES)) u_tbl (
		.clk(clk), .arst_n(arst_n),
		.wr(tw), .gm_wdata(sig_q),
		.rd_en(tb_re), .ctg_raddr(first_q), .gm_raddr(gidx_q),
		.ctg_hit(ctg_hit), .ctg_group(ctg_group), .gm_rdata(gm_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q  <= '0;
			token_offset_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == ccp_pkg::REG_CLASS_COUNT)
				class_count_q <= cfg.data[ccp_pkg::CCNT_W-1:0];
			else if (cfg.index == ccp_pkg::REG_TOKEN_OFFSET)
				token_offset_q <= cfg.data[ccp_pkg::TOFF_W-1:0];
		end
	end

	// command word, payload only
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			mode_q  <= in_ch.mode;
			slot_q  <= in_ch.class_slot;
			other_q <= in_ch.other_slot;
			first_q <= in_ch.start_char;
			last_q  <= in_ch.last_char;
			gidx_q  <= in_ch.group_index;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			groups_q    <= '0;
			rem_q       <= '0;
			keep_q      <= '0;
			drop_q      <= '0;
			sig_q       <= '0;
			ptr_q       <= '0;
			scan_q      <= '0;
			n_q         <= '0;
			iss_q       <= '0;
			rv_s1       <= 1'b0;
			ridx_s1     <= '0;
			res_cg_q    <= '0;
			res_mb_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_gc_q    <= '0;
			out_cg_q    <= '0;
			out_mb_q    <= 1'b0;
		end else begin
			rv_s1   <= cm_re && (state_q == S_UNION || state_q == S_KEEP);
			ridx_s1 <= iss_q[AW-1:0];
			if (cm_re && (state_q == S_UNION || state_q == S_KEEP))
				iss_q <= iss_q + 1'b1;

			// result register: loaded from the response state, emptied by the receiver
			if (state_q == S_RESP && (!out_valid_q || out_ch.ready))
				out_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						res_cg_q <= '0;
						res_mb_q <= 1'b0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (mode_q)
						ccp_pkg::MODE_CLEAR: state_q <= S_RESP;
						ccp_pkg::MODE_PARTITION: begin
							groups_q <= '0;
							rem_q    <= '0;
							n_q      <= active_n;
							iss_q    <= '0;
							state_q  <= S_UNION;
						end
						ccp_pkg::MODE_ADD, ccp_pkg::MODE_INVERT, ccp_pkg::MODE_SUBTRACT,
						ccp_pkg::MODE_LOOKUP, ccp_pkg::MODE_MEMBER: state_q <= S_APPLY;
						default: state_q <= S_RESP;
					endcase
				end
				S_APPLY: begin
					if (mode_q == ccp_pkg::MODE_SUBTRACT) begin
						keep_q  <= cm_rdata;
						state_q <= S_SUB;
					end else begin
						if (mode_q == ccp_pkg::MODE_LOOKUP)
							res_cg_q <= ctg_hit ? $signed(ccp_pkg::CGRP_W'(ctg_group)
								+ ccp_pkg::CGRP_W'(token_offset_q)) : ccp_pkg::NO_GROUP;
						if (mode_q == ccp_pkg::MODE_MEMBER)
							res_mb_q <= slot_ok && (ccp_pkg::GROUP_W'(gidx_q) < groups_q)
								&& gm_rdata[slot_idx];
						state_q <= S_RESP;
					end
				end
				S_SUB: state_q <= S_RESP;
				S_UNION: begin
					if (rv_s1)
						rem_q <= rem_q | cm_rdata;
					if (stream_done) begin
						ptr_q   <= '0;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					// pointer only moves up: the lowest remaining char never decreases
					if (groups_q == ccp_pkg::MAX_GROUPS)
						state_q <= S_RESP;
					else if (rem_q[ptr_q]) begin
						keep_q  <= '1;
						drop_q  <= '0;
						sig_q   <= '0;
						iss_q   <= '0;
						state_q <= S_KEEP;
					end else if (ptr_q == 8'hFF)
						state_q <= S_RESP;
					else
						ptr_q <= ptr_q + 1'b1;
				end
				S_KEEP: begin
					if (rv_s1) begin
						if (cm_rdata[ptr_q]) begin
							keep_q         <= keep_q & cm_rdata;
							sig_q[ridx_s1] <= 1'b1;
						end else
							drop_q <= drop_q | cm_rdata;
					end
					if (stream_done) begin
						keep_q  <= keep_q & ~drop_q;
						scan_q  <= ptr_q;
						state_q <= S_MARK;
					end
				end
				S_MARK: begin
					if (scan_q == 8'hFF) begin
						rem_q    <= rem_q & ~keep_q;
						groups_q <= groups_q + 1'b1;
						state_q  <= S_FIND;
					end else
						scan_q <= scan_q + 1'b1;
				end
				S_RESP: begin
					if (!out_valid_q || out_ch.ready) begin
						out_gc_q    <= groups_q;
						out_cg_q    <= res_cg_q;
						out_mb_q    <= res_mb_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.group_count = out_gc_q;
	assign out_ch.char_group  = out_cg_q;
	assign out_ch.is_member   = out_mb_q;

endmodule

[rtl/ccp_class_mem.sv]
// Class set memory: one 256-bit row per class, row valid flags give the empty reset.
`timescale 1ns / 1ps
module ccp_class_mem #(
	parameter int ROWS = 32,
	parameter int AW   = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [ccp_pkg::CHARS-1:0]  rdata,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [ccp_pkg::CHARS-1:0]  wdata
);

	logic [ccp_pkg::CHARS-1:0] mem [ROWS];
	logic [ROWS-1:0]           row_ok_q;
	logic [ccp_pkg::CHARS-1:0] rdata_q;
	logic                      rd_ok_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			if (we)
				row_ok_q[waddr] <= 1'b1;
			if (re)
				rd_ok_q <= row_ok_q[raddr];
		end
	end

	// never-written rows read as empty
	assign rdata = rd_ok_q ? rdata_q : '0;

endmodule

[rtl/ccp_tables.sv]
// Partition results: character-to-group table and per-group class vectors.
`timescale 1ns / 1ps
module ccp_tables #(
	parameter int CLASSES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ccp_pkg::tbl_wr_t            wr,
	input  logic [CLASSES-1:0]          gm_wdata,
	input  logic                        rd_en,
	input  logic [ccp_pkg::CHAR_W-1:0]  ctg_raddr,
	input  logic [ccp_pkg::CHAR_W-1:0]  gm_raddr,
	output logic                        ctg_hit,
	output logic [ccp_pkg::CHAR_W-1:0]  ctg_group,
	output logic [CLASSES-1:0]          gm_rdata
);

	logic [ccp_pkg::CHAR_W-1:0] ctg_mem [ccp_pkg::CHARS];
	logic [CLASSES-1:0]         gm_mem  [ccp_pkg::CHARS];
	logic [ccp_pkg::CHARS-1:0]  ctg_ok_q;
	logic [ccp_pkg::CHAR_W-1:0] ctg_rd_q;
	logic [CLASSES-1:0]         gm_rd_q;
	logic                       hit_q;

	always_ff @(posedge clk) begin
		if (wr.ctg_we)
			ctg_mem[wr.ctg_addr] <= wr.ctg_group;
		if (wr.gm_we)
			gm_mem[wr.gm_addr] <= gm_wdata;
		if (rd_en) begin
			ctg_rd_q <= ctg_mem[ctg_raddr];
			gm_rd_q  <= gm_mem[gm_raddr];
		end
	end

	// per-character valid flags; a cleared entry means "no group"
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctg_ok_q <= '0;
			hit_q    <= 1'b0;
		end else begin
			if (wr.ctg_clear)
				ctg_ok_q <= '0;
			else if (wr.ctg_we)
				ctg_ok_q[wr.ctg_addr] <= 1'b1;
			if (rd_en)
				hit_q <= ctg_ok_q[ctg_raddr];
		end
	end

	assign ctg_hit   = hit_q;
	assign ctg_group = ctg_rd_q;
	assign gm_rdata  = gm_rd_q;

endmodule

[rtl/ccp_checker.sv]
// Port-level checks of the character class partitioner, bound to the top level.
`timescale 1ns / 1ps
module ccp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [ccp_pkg::GROUP_W-1:0]       group_count,
	input logic signed [ccp_pkg::CGRP_W-1:0] char_group,
	input logic                              is_member
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(group_count)
		&& $stable(char_group) && $stable(is_member))
		else $error("result word changed under stall");

	// one command in flight: no word taken right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	// a membership answer comes only from a membership test
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_member |-> char_group == 0)
		else $error("lookup and membership fields both set");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> group_count <= ccp_pkg::MAX_GROUPS)
		else $error("group count beyond alphabet");

endmodule

bind char_class_partitioner_top ccp_checker u_ccp_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.group_count(out_ch.group_count), .char_group(out_ch.char_group),
	.is_member(out_ch.is_member)
);
